@@ rtl/command_frame_receiver_top_defines.svh @@
// Assertion helpers used by the checker file.
`ifndef COMMAND_FRAME_RECEIVER_TOP_DEFINES_SVH
`define COMMAND_FRAME_RECEIVER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CFR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cfr assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CFR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cfr assertion failed");

`endif

@@ rtl/cfr_pkg.sv @@
package cfr_pkg;

	localparam int CNT_W             = 7;
	localparam int CFR_MAX_FRAME     = 64;
	localparam int VALID_FRAME_BYTES = 7;
	localparam int VALID_PAYLOAD     = VALID_FRAME_BYTES - 4;

	localparam logic [7:0] MARK_START = 8'h3E;
	localparam logic [7:0] MARK_END   = 8'h3C;
	localparam logic [7:0] CMD_START  = 8'h73;
	localparam logic [7:0] CMD_STOP   = 8'h63;
	localparam logic [7:0] CMD_PAUSE  = 8'h70;
	localparam logic [7:0] CMD_CALIB  = 8'h6B;

	localparam logic [2:0] ST_START   = 3'd0;
	localparam logic [2:0] ST_STOP    = 3'd1;
	localparam logic [2:0] ST_PAUSE   = 3'd2;
	localparam logic [2:0] ST_CALIB   = 3'd3;
	localparam logic [2:0] ST_UNKNOWN = 3'd4;
	localparam logic [2:0] ST_BADSUM  = 3'd5;
	localparam logic [2:0] ST_LENGTH  = 3'd6;
	localparam logic [2:0] ST_SHORT   = 3'd7;

	typedef struct packed {
		logic [7:0] rx_byte;
	} rx_item_t;

	typedef struct packed {
		logic [2:0] frame_status;
		logic [7:0] command_code;
		logic [7:0] command_arg;
	} report_item_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [7:0]       sum;
		logic [7:0]       last;
		logic [7:0]       first;
		logic [7:0]       second;
	} frame_t;

	typedef struct packed {
		frame_t frame;
		logic   ovf;
	} take_t;

	typedef struct packed {
		logic finish;
		logic ovf;
	} frame_end_t;

	// Append one payload byte; flag overflow when the frame is already full.
	function automatic take_t take_payload(frame_t f, logic [7:0] b,
			logic [CNT_W-1:0] max_cnt);
		take_t t;
		t.frame = f;
		t.ovf   = (f.count >= max_cnt);
		if (f.count != '0) begin
			t.frame.sum = f.sum + f.last;
		end
		t.frame.last = b;
		if (f.count == CNT_W'(0)) begin
			t.frame.first = b;
		end else if (f.count == CNT_W'(1)) begin
			t.frame.second = b;
		end
		t.frame.count = f.count + CNT_W'(1);
		return t;
	endfunction

endpackage

@@ rtl/cfr_stream_if.sv @@
interface cfr_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/cfr_collect.sv @@
module cfr_collect import cfr_pkg::*; #(
	parameter int MAX_FRAME = CFR_MAX_FRAME
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] rx_byte,
	output frame_t     frame,
	output frame_end_t frame_end
);

	localparam logic [1:0] PH_HUNT    = 2'd0;
	localparam logic [1:0] PH_ONE     = 2'd1;
	localparam logic [1:0] PH_COLLECT = 2'd2;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME);

	logic [1:0] phase_q, phase_d;
	logic       held_q, held_d;
	frame_t     frame_q, frame_d;
	take_t      take_lt, take_b;
	frame_t     base;

	// Held '<' goes in first, then the current byte.
	always_comb begin
		take_lt = take_payload(frame_q, MARK_END, MAX_CNT);
		base    = held_q ? take_lt.frame : frame_q;
		take_b  = take_payload(base, rx_byte, MAX_CNT);
	end

	always_comb begin
		phase_d   = phase_q;
		held_d    = held_q;
		frame_d   = frame_q;
		frame_end = '0;
		unique case (phase_q)
			PH_HUNT: begin
				if (rx_byte == MARK_START) phase_d = PH_ONE;
			end
			PH_ONE: begin
				if (rx_byte == MARK_START) begin
					phase_d = PH_COLLECT;
					held_d  = 1'b0;
					frame_d = '0;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_COLLECT: begin
				if (rx_byte == MARK_END) begin
					if (held_q) begin
						frame_end.finish = 1'b1;
						phase_d          = PH_HUNT;
						held_d           = 1'b0;
						frame_d          = '0;
					end else begin
						held_d = 1'b1;
					end
				end else if ((held_q && take_lt.ovf) || take_b.ovf) begin
					frame_end.ovf = 1'b1;
					phase_d       = PH_HUNT;
					held_d        = 1'b0;
					frame_d       = '0;
				end else begin
					held_d  = 1'b0;
					frame_d = take_b.frame;
				end
			end
			default: phase_d = PH_HUNT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			held_q  <= 1'b0;
			frame_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			held_q  <= held_d;
			frame_q <= frame_d;
		end
	end

	assign frame = frame_q;

endmodule

@@ rtl/cfr_verdict.sv @@
module cfr_verdict import cfr_pkg::*; (
	input  frame_t       frame,
	input  frame_end_t   frame_end,
	output logic         emit,
	output report_item_t res
);

	logic [2:0] cmd_status;

	always_comb begin
		unique case (frame.first)
			CMD_START: cmd_status = ST_START;
			CMD_STOP:  cmd_status = ST_STOP;
			CMD_PAUSE: cmd_status = ST_PAUSE;
			CMD_CALIB: cmd_status = ST_CALIB;
			default:   cmd_status = ST_UNKNOWN;
		endcase
	end

	// Order decides: short, checksum, unknown command, length.
	always_comb begin
		emit = frame_end.finish || frame_end.ovf;
		res  = '{frame_status: ST_SHORT, command_code: 8'h00, command_arg: 8'h00};
		if (frame_end.finish && frame.count >= CNT_W'(2)) begin
			res.command_code = frame.first;
			res.command_arg  = frame.second;
			priority if (frame.sum != frame.last) begin
				res.frame_status = ST_BADSUM;
			end else if (cmd_status == ST_UNKNOWN) begin
				res.frame_status = ST_UNKNOWN;
			end else if (frame.count != CNT_W'(VALID_PAYLOAD)) begin
				res.frame_status = ST_LENGTH;
			end else begin
				res.frame_status = cmd_status;
			end
		end
	end

endmodule

@@ rtl/command_frame_receiver_top.sv @@
// Command frame receiver.
// rx carries one received byte per request (rx.data.rx_byte). report carries
// one status request per frame: frame_status, command_code and command_arg.
// Frames open with ">>", close with "<<"; the last payload byte is an 8-bit
// checksum of the bytes before it. Overflow past MAX_FRAME payload bytes ends
// the frame at once with status 7 and hunting resumes.
// Path: an accepted byte is held in the input stage, decoded by the collect and
// verdict logic, and its status is loaded into the status register for report.
// Throughput: one byte per cycle while report is not stalled; rx.ready stays high while report drains.
// Stall: when report.valid is high and report.ready low, the status holds,
// the decode stage holds its byte, and rx.ready drops once that stage is full.
// Reset (arst_n low) drops any pending byte and status and returns the
// receiver to hunting for a start mark.
module command_frame_receiver_top import cfr_pkg::*; #(
	parameter int MAX_FRAME = CFR_MAX_FRAME
) (
	input logic          clk,
	input logic          arst_n,
	cfr_stream_if.sink   rx,
	cfr_stream_if.source report
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         report_valid_s2;
	report_item_t report_s2;

	logic         advance;
	logic         fire;
	frame_t       frame;
	frame_end_t   frame_end;
	logic         emit;
	report_item_t res;

	// Advance the decode stage whenever the status register is free or draining.
	assign advance  = !report_valid_s2 || report.ready;
	assign fire     = valid_s1 && advance;
	assign rx.ready = !valid_s1 || advance;

	// Input stage: hold the byte until the decode stage takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) byte_s1 <= rx.data.rx_byte;
	end

	cfr_collect #(
		.MAX_FRAME(MAX_FRAME)
	) u_collect (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.rx_byte   (byte_s1),
		.frame     (frame),
		.frame_end (frame_end)
	);

	cfr_verdict u_verdict (
		.frame     (frame),
		.frame_end (frame_end),
		.emit      (emit),
		.res       (res)
	);

	// Status register: load a new status only when one is produced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_valid_s2 <= 1'b0;
		end else if (advance) begin
			report_valid_s2 <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) report_s2 <= res;
	end

	assign report.valid = report_valid_s2;
	assign report.data  = report_s2;

endmodule

@@ rtl/cfr_checker.sv @@
`include "command_frame_receiver_top_defines.svh"

module cfr_checker import cfr_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       report_valid,
	input logic       report_ready,
	input logic [2:0] frame_status,
	input logic [7:0] command_code,
	input logic [7:0] command_arg
);

	// A stalled status request holds.
	`CFR_ASSERT_NEXT(a_report_hold, report_valid && !report_ready,
		report_valid && $stable(frame_status) && $stable(command_code) && $stable(command_arg))

	// Short or overflowed frames carry no command bytes.
	`CFR_ASSERT_NOW(a_short_zero, report_valid && frame_status == ST_SHORT,
		command_code == 8'h00 && command_arg == 8'h00)

	// An accepted command status matches its command byte.
	`CFR_ASSERT_NOW(a_cmd_match, report_valid && frame_status < ST_UNKNOWN,
		(frame_status == ST_START && command_code == CMD_START) ||
		(frame_status == ST_STOP && command_code == CMD_STOP) ||
		(frame_status == ST_PAUSE && command_code == CMD_PAUSE) ||
		(frame_status == ST_CALIB && command_code == CMD_CALIB))

endmodule

bind command_frame_receiver_top cfr_checker u_cfr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.report_valid (report.valid),
	.report_ready (report.ready),
	.frame_status (report.data.frame_status),
	.command_code (report.data.command_code),
	.command_arg  (report.data.command_arg)
);
